// ===== hdl/bsc_pkg.sv =====
// Shared types, widths and codes for the bitmap set/clear/find-first block.
package bsc_pkg;

	localparam int DEF_BITMAP_BITS = 1024;

	localparam int KIND_W  = 2;
	localparam int OFF_W   = 10;
	localparam int SW_W    = 11;
	localparam int POS_W   = 10;
	localparam int MAX_WIN = 1024;

	// Storage word and window-relative indexing
	localparam int WORD_W = 64;
	localparam int BIT_W  = 6;   // bit within a word
	localparam int SCAN_W = 6;   // word index reachable by offset + window
	localparam int IDX_W  = SCAN_W + BIT_W;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_CLEAR  = 2'd0;
	localparam kind_t KIND_SET    = 2'd1;
	localparam kind_t KIND_SEARCH = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic load;       // capture request fields
		logic sweep_wr;   // zero one word of the reset sweep
		logic rmw_rd;     // read word holding the addressed bit
		logic rmw_wr;     // write modified word back
		logic srch_rd;    // read first word of the window
		logic srch_next;  // advance to and read next word
		logic res_hit;    // capture search hit as result
		logic res_miss;   // capture empty result
		logic out_load;   // move result into output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_last;
		logic win_empty;
		logic hit;
		logic more;
	} sts_t;

endpackage

// ===== hdl/bsc_dp.sv =====
// Datapath: bitmap word memory, read-modify-write and windowed first-one search.
module bsc_dp import bsc_pkg::*; #(
	parameter int BITMAP_BITS = DEF_BITMAP_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  kind_t                  in_kind,
	input  logic [OFF_W-1:0]       in_offset,
	input  logic [SW_W-1:0]        in_search_width,
	output logic                   out_found,
	output logic [POS_W-1:0]       out_position
);

	localparam int NUM_WORDS = (BITMAP_BITS + WORD_W - 1) / WORD_W;
	localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	logic [WORD_W-1:0] mem [NUM_WORDS];

	logic [OFF_W-1:0]  off_q;
	logic              bit_set_q;
	logic [IDX_W-1:0]  lim_q;
	logic [SCAN_W-1:0] scan_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [WORD_W-1:0] rdata_q;
	logic              res_found_q;
	logic [POS_W-1:0]  res_pos_q;
	logic              out_found_q;
	logic [POS_W-1:0]  out_pos_q;

	logic [SW_W-1:0]   win_w;
	logic [IDX_W-1:0]  end_w;
	logic [IDX_W-1:0]  lim_w;
	logic [SCAN_W-1:0] scan_nxt;
	logic [SCAN_W-1:0] off_word;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_en;
	logic              in_range;
	logic [WORD_W-1:0] bit_mask;
	logic [WORD_W-1:0] wr_word;
	logic [BIT_W:0]    lo;
	logic [BIT_W:0]    hi;
	logic [WORD_W-1:0] hit_vec;
	logic [BIT_W-1:0]  hit_bit;
	logic [IDX_W-1:0]  hit_dist;

	// Window end clipped to the bitmap size; bits past it read as zero
	assign win_w = (in_search_width > SW_W'(MAX_WIN)) ? SW_W'(MAX_WIN) : in_search_width;
	assign end_w = IDX_W'(in_offset) + IDX_W'(win_w);
	assign lim_w = (32'(end_w) > BITMAP_BITS) ? IDX_W'(BITMAP_BITS) : end_w;

	assign off_word = SCAN_W'(off_q[OFF_W-1:BIT_W]);
	assign scan_nxt = scan_q + SCAN_W'(1);
	assign in_range = 32'(off_q) < BITMAP_BITS;

	always_comb begin
		if (cmd.srch_next) begin
			rd_addr = ADDR_W'(scan_nxt);
		end else if (cmd.srch_rd) begin
			rd_addr = ADDR_W'(scan_q);
		end else begin
			rd_addr = ADDR_W'(off_word);
		end
	end
	assign rd_en = cmd.rmw_rd | cmd.srch_rd | cmd.srch_next;

	assign bit_mask = WORD_W'(1) << off_q[BIT_W-1:0];
	assign wr_word  = bit_set_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);

	always_ff @(posedge clk) begin
		if (cmd.sweep_wr) begin
			mem[sweep_q] <= '0;
		end else if (cmd.rmw_wr && in_range) begin
			mem[ADDR_W'(off_word)] <= wr_word;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Valid bit range [lo, hi) of the current word
	always_comb begin
		lo = (scan_q == off_word) ? {1'b0, off_q[BIT_W-1:0]} : '0;
		hi = (scan_q == lim_q[IDX_W-1:BIT_W]) ? {1'b0, lim_q[BIT_W-1:0]} : (BIT_W+1)'(WORD_W);
		for (int b = 0; b < WORD_W; b++) begin
			hit_vec[b] = rdata_q[b] && ((BIT_W+1)'(b) >= lo) && ((BIT_W+1)'(b) < hi);
		end
	end

	always_comb begin
		hit_bit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (hit_vec[b]) begin
				hit_bit = BIT_W'(b);
			end
		end
	end

	assign hit_dist = {scan_q, hit_bit} - IDX_W'(off_q);

	assign sts.sweep_last = (sweep_q == ADDR_W'(NUM_WORDS - 1));
	assign sts.win_empty  = (lim_q <= IDX_W'(off_q));
	assign sts.hit        = |hit_vec;
	assign sts.more       = ({scan_nxt, BIT_W'(0)} < lim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_wr) begin
			sweep_q <= sweep_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			off_q     <= in_offset;
			bit_set_q <= (in_kind == KIND_SET);
			lim_q     <= lim_w;
			scan_q    <= SCAN_W'(in_offset[OFF_W-1:BIT_W]);
		end else if (cmd.srch_next) begin
			scan_q <= scan_nxt;
		end
		if (cmd.res_hit) begin
			res_found_q <= 1'b1;
			res_pos_q   <= hit_dist[POS_W-1:0];
		end else if (cmd.res_miss) begin
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
		end
		if (cmd.out_load) begin
			out_found_q <= res_found_q;
			out_pos_q   <= res_pos_q;
		end
	end

	assign out_found    = out_found_q;
	assign out_position = out_pos_q;

endmodule

// ===== hdl/bsc_ctrl.sv =====
// Controller: reset sweep, request sequencing and output valid.
module bsc_ctrl import bsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  kind_t in_kind,
	output logic  m_tvalid,
	input  logic  m_tready,
	input  sts_t  sts,
	output cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_SWEEP    = 7'b0000001,
		S_IDLE     = 7'b0000010,
		S_RMW_RD   = 7'b0000100,
		S_RMW_WR   = 7'b0001000,
		S_SRCH_RD  = 7'b0010000,
		S_SRCH_CHK = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	state_t state_q, state_nxt;
	logic   m_valid_q;
	logic   accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					unique case (in_kind) inside
						KIND_CLEAR, KIND_SET: state_nxt = S_RMW_RD;
						KIND_SEARCH:          state_nxt = S_SRCH_RD;
						default: begin
							cmd.res_miss = 1'b1;
							state_nxt    = S_DONE;
						end
					endcase
				end
			end
			S_RMW_RD: begin
				cmd.rmw_rd = 1'b1;
				state_nxt  = S_RMW_WR;
			end
			S_RMW_WR: begin
				cmd.rmw_wr   = 1'b1;
				cmd.res_miss = 1'b1;
				state_nxt    = S_DONE;
			end
			S_SRCH_RD: begin
				if (sts.win_empty) begin
					cmd.res_miss = 1'b1;
					state_nxt    = S_DONE;
				end else begin
					cmd.srch_rd = 1'b1;
					state_nxt   = S_SRCH_CHK;
				end
			end
			S_SRCH_CHK: begin
				if (sts.hit) begin
					cmd.res_hit = 1'b1;
					state_nxt   = S_DONE;
				end else if (sts.more) begin
					cmd.srch_next = 1'b1;
				end else begin
					cmd.res_miss = 1'b1;
					state_nxt    = S_DONE;
				end
			end
			S_DONE: begin
				if (!m_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;

endmodule

// ===== hdl/bitmap_set_clear_find_first.sv =====
// Top level of the bitmap set/clear/find-first block.
// A bitmap of BITMAP_BITS bits lives in a memory of 64-bit words. Each request
// clears one bit, sets one bit, or searches [offset, offset+search_width) for
// its first one and returns the distance from offset (width clipped to 1024,
// bits past the bitmap end read as zero). Every request gives exactly one
// result; set, clear and the unused kind return found=0, position=0.
// After reset the block zeroes the memory one word per cycle with s_tready low.
// Set and clear read the word, write it back and hand off the result. A search
// reads one word per cycle through the single memory read port, up to the hit:
// at most 16 words with the default 1024-bit bitmap, 17 when a larger bitmap
// lets an unaligned 1024-bit window span 17 words; an empty window reads no
// word. One request is in flight at a time; the next is taken while the
// previous result still waits in the output register.
module bitmap_set_clear_find_first import bsc_pkg::*; #(
	parameter int BITMAP_BITS = DEF_BITMAP_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // kind[1:0], offset[11:2], search_width[22:12]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // found[0], position[10:1]
);

	cmd_t            cmd;
	sts_t            sts;
	kind_t           in_kind;
	logic [OFF_W-1:0] in_offset;
	logic [SW_W-1:0]  in_search_width;
	logic            out_found;
	logic [POS_W-1:0] out_position;

	// Request unpacking
	assign in_kind         = s_tdata[KIND_W-1:0];
	assign in_offset       = s_tdata[KIND_W+OFF_W-1:KIND_W];
	assign in_search_width = s_tdata[KIND_W+OFF_W+SW_W-1:KIND_W+OFF_W];

	bsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_kind  (in_kind),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsc_dp #(
		.BITMAP_BITS (BITMAP_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_kind         (in_kind),
		.in_offset       (in_offset),
		.in_search_width (in_search_width),
		.out_found       (out_found),
		.out_position    (out_position)
	);

	// Result packing, upper bits zero
	assign m_tdata = {(OUT_TDATA_W-1-POS_W)'(0), out_position, out_found};

endmodule

// ===== hdl/bsc_chk.sv =====
// Port-level checks for the bitmap set/clear/find-first block, bound to the top.
module bsc_chk import bsc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A miss never reports a distance
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[POS_W:1] == '0)
		else $error("miss with nonzero position");

	// Padding stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:POS_W+1] == '0)
		else $error("output padding not zero");

	// One request in flight: no accept on the following cycle
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// A request never produces a new result on the next edge
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (!m_tvalid || m_tready) |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind bitmap_set_clear_find_first bsc_chk u_bsc_chk (.*);

// ===== bench/bitmap_set_clear_find_first_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bitmap_set_clear_find_first: predicted set/clear/search results, random stalls.
module bitmap_set_clear_find_first_tb;
	import bsc_pkg::*;

	localparam int    BITS        = DEF_BITMAP_BITS;
	localparam int    REPORT_MAX  = 10;
	localparam int    RANDOM_REQS = 400;
	localparam int    DRAIN_CYC   = 40;
	localparam kind_t KIND_UNUSED = 2'd3;   // no operation, still answered

	// One response as it leaves the block
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} result_t;

	// Keeps a private copy of the bitmap, works out the response of every accepted
	// request and compares responses in order.
	class bitmap_scoreboard;
		bit [BITS-1:0] bits;
		result_t       expected_q[$];
		int            mismatches;
		int            requests;
		int            searches;
		int            hits;

		function new();
			bits       = '0;
			mismatches = 0;
			requests   = 0;
			searches   = 0;
			hits       = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= REPORT_MAX) begin
				$display("%0t: mismatch: %s", $realtime, msg);
			end
		endfunction

		// Apply one accepted request to the bitmap copy and queue its response.
		function void note_request(kind_t kind, logic [OFF_W-1:0] offset,
			logic [SW_W-1:0] width);
			result_t r;
			int      span;
			r = '0;
			requests++;
			case (kind)
				KIND_CLEAR: begin
					if (offset < BITS) bits[offset] = 1'b0;
				end
				KIND_SET: begin
					if (offset < BITS) bits[offset] = 1'b1;
				end
				KIND_SEARCH: begin
					searches++;
					// windows wider than the bitmap are clipped; bits past the end read 0
					span = (width > MAX_WIN) ? MAX_WIN : int'(width);
					for (int i = 0; i < span && !r.found; i++) begin
						if (int'(offset) + i < BITS && bits[int'(offset) + i]) begin
							r.found    = 1'b1;
							r.position = POS_W'(i);
						end
					end
					if (r.found) hits++;
				end
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_result(logic found, logic [POS_W-1:0] position);
			result_t exp_r;
			if (expected_q.size() == 0) begin
				report($sformatf("response with none pending: found=%0d position=%0d",
					found, position));
				return;
			end
			exp_r = expected_q.pop_front();
			if (found !== exp_r.found)
				report($sformatf("found: expected %0d, got %0d", exp_r.found, found));
			if (position !== exp_r.position)
				report($sformatf("position: expected %0d, got %0d",
					exp_r.position, position));
		endfunction
	endclass

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // kind[1:0], offset[11:2], search_width[22:12]
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // found[0], position[10:1]

	bitmap_scoreboard sb = new();

	// Sender burst state
	int burst_left = 0;

	// Receiver stall pattern: mode held for a random number of cycles
	int rx_mode = 0;
	int rx_left = 0;

	// Offsets that were set by random requests, so clears and searches hit live bits
	logic [OFF_W-1:0] live_bits[$];

	bitmap_set_clear_find_first u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Response side: check on handshake, then pick next tready.
	// Mode 0 always ready, mode 1 mostly ready, mode 2 long stalls.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata[0], m_tdata[POS_W:1]);
		end
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_left <= $urandom_range(20, 120);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Hand one request to the block and hold it until taken. tvalid stays high
	// across a burst; a gap between bursts drops it.
	task automatic issue(kind_t kind, logic [OFF_W-1:0] offset, logic [SW_W-1:0] width);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, width, offset, kind};
		do @(posedge clk); while (!s_tready);
		sb.note_request(kind, offset, width);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			// now and then a long burst with no gap at all
			if ($urandom_range(0, 3) == 0) begin
				gap        = 0;
				burst_left = $urandom_range(20, 40);
			end else begin
				gap        = $urandom_range(0, 6);
				burst_left = $urandom_range(1, 12);
			end
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Offset biased toward bitmap ends and 64-bit word edges.
	function automatic logic [OFF_W-1:0] pick_offset();
		int w;
		case ($urandom_range(0, 3))
			0: begin
				return ($urandom_range(0, 1) != 0) ? OFF_W'($urandom_range(0, 7))
				                                  : OFF_W'($urandom_range(BITS - 8, BITS - 1));
			end
			1: begin
				w = $urandom_range(1, BITS / 64 - 1) * 64;
				return OFF_W'(w - 1 + $urandom_range(0, 2));
			end
			default: return OFF_W'($urandom_range(0, BITS - 1));
		endcase
	endfunction

	task automatic random_request();
		int               sel;
		int               idx;
		int               base;
		logic [OFF_W-1:0] offset;
		logic [SW_W-1:0]  width;
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			offset = pick_offset();
			if (live_bits.size() < 64) live_bits.push_back(offset);
			issue(KIND_SET, offset, SW_W'($urandom));
		end else if (sel < 55) begin
			if (live_bits.size() > 0 && $urandom_range(0, 9) < 7) begin
				idx    = $urandom_range(0, live_bits.size() - 1);
				offset = live_bits[idx];
				live_bits.delete(idx);
			end else begin
				offset = pick_offset();
			end
			issue(KIND_CLEAR, offset, SW_W'($urandom));
		end else if (sel < 95) begin
			// start a little below a live bit about half the time
			if (live_bits.size() > 0 && $urandom_range(0, 1) != 0) begin
				base   = live_bits[$urandom_range(0, live_bits.size() - 1)];
				base   = base - $urandom_range(0, 130);
				offset = OFF_W'((base < 0) ? 0 : base);
			end else begin
				offset = pick_offset();
			end
			case ($urandom_range(0, 19))
				0:                width = '0;
				1, 2:             width = SW_W'($urandom_range(MAX_WIN + 1, 2047));
				3, 4, 5, 6, 7:    width = SW_W'($urandom_range(0, MAX_WIN));
				default:          width = SW_W'($urandom_range(1, 200));
			endcase
			issue(KIND_SEARCH, offset, width);
		end else begin
			issue(KIND_UNUSED, OFF_W'($urandom), SW_W'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n     <= 1'b1;
		burst_left = $urandom_range(1, 12);
		@(posedge clk);

		// Directed: empty bitmap, bitmap ends, clipped and zero windows, unused kind
		issue(KIND_SEARCH, '0, SW_W'(MAX_WIN));          // nothing set yet
		issue(KIND_SET,    '0, '0);
		issue(KIND_SET,    '1, '1);                      // last bit
		issue(KIND_SEARCH, '0, SW_W'(1));                // hit at distance 0
		issue(KIND_SEARCH, '0, '0);                      // zero width never hits
		issue(KIND_SEARCH, OFF_W'(1), SW_W'(MAX_WIN));   // runs to the last bit
		issue(KIND_SEARCH, OFF_W'(1), '1);               // oversized width clipped
		issue(KIND_SEARCH, OFF_W'(1000), SW_W'(24));     // last bit is the final one looked at
		issue(KIND_SEARCH, OFF_W'(1000), SW_W'(23));     // window stops one short
		issue(KIND_UNUSED, '1, '1);                      // no change
		issue(KIND_SEARCH, '1, SW_W'(1));
		issue(KIND_CLEAR,  '1, '1);
		issue(KIND_SEARCH, OFF_W'(1020), SW_W'(100));    // window past the end, now empty
		issue(KIND_SET,    OFF_W'(63), '0);              // word edge
		issue(KIND_SET,    OFF_W'(64), '0);
		issue(KIND_SEARCH, OFF_W'(2), SW_W'(MAX_WIN));   // first hit below a word edge
		issue(KIND_CLEAR,  OFF_W'(63), '0);
		issue(KIND_SEARCH, OFF_W'(2), SW_W'(MAX_WIN));   // crosses into the next word
		issue(KIND_SEARCH, OFF_W'(65), SW_W'(MAX_WIN));  // only bits below the start are set
		issue(KIND_CLEAR,  '0, '0);
		issue(KIND_CLEAR,  OFF_W'(64), '0);
		issue(KIND_SEARCH, '0, SW_W'(MAX_WIN));          // empty again
		issue(KIND_UNUSED, '0, '0);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			random_request();
		end
		if (s_tvalid) s_tvalid <= 1'b0;

		// Drain: every expected response back, then a little settle time
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Ran %0d requests: %0d searches, %0d of them hitting a set bit.",
			sb.requests, sb.searches, sb.hits);
		$display("Mismatches: %0d, responses still outstanding: %0d.",
			sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("bitmap_set_clear_find_first_tb passed");
		end else begin
			$display("bitmap_set_clear_find_first_tb failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Timeout with %0d responses outstanding.", sb.pending());
		$display("bitmap_set_clear_find_first_tb failed");
		$finish;
	end

endmodule
